// File: design/utf8s_pkg.sv
package utf8s_pkg;

    localparam int MAX_SEQ_BYTES = 4;
    localparam int MAX_RESULTS   = 7;
    localparam int CNT_W         = 3;

    localparam logic [7:0] REPL_B0 = 8'hef;
    localparam logic [7:0] REPL_B1 = 8'hbf;
    localparam logic [7:0] REPL_B2 = 8'hbd;

    typedef logic [MAX_SEQ_BYTES-1:0][7:0] t_grp_bytes;

    // sanitized form of one closed group
    typedef struct packed {
        t_grp_bytes        bytes;
        logic [CNT_W-1:0]  n;
    } t_seq;

    // all results caused by one input byte
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            n;
        logic                        text_end;
    } t_burst;

    function automatic logic grp_valid(input t_grp_bytes g, input logic [CNT_W-1:0] n);
        logic [31:0] v;
        logic        len_ok;
        logic        ok;
        v      = '0;
        len_ok = 1'b1;
        ok     = 1'b0;
        case (n)
            3'd1:    v = {24'd0, g[0]};
            3'd2:    v = {16'd0, g[0], g[1]};
            3'd3:    v = {8'd0, g[0], g[1], g[2]};
            3'd4:    v = {g[0], g[1], g[2], g[3]};
            default: len_ok = 1'b0;
        endcase
        if (!len_ok) begin
            ok = 1'b0;
        end else if (v <= 32'h7f) begin
            ok = 1'b1;
        end else if (v >= 32'hc280 && v <= 32'hdfbf) begin
            ok = (v & 32'he0c0) == 32'hc080;
        end else if (v >= 32'heda080 && v <= 32'hedbfbf) begin
            ok = 1'b0;
        end else if (v >= 32'he0a080 && v <= 32'hefbfbf) begin
            ok = (v & 32'hf0c0c0) == 32'he08080;
        end else if (v >= 32'hf0908080 && v <= 32'hf48fbfbf) begin
            ok = (v & 32'hf8c0c0c0) == 32'hf0808080;
        end else begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic t_seq grp_emit(input t_grp_bytes g, input logic [CNT_W-1:0] n);
        t_seq s;
        if (grp_valid(g, n)) begin
            s.bytes = g;
            s.n     = n;
        end else begin
            s.bytes = {8'd0, REPL_B2, REPL_B1, REPL_B0};
            s.n     = 3'd3;
        end
        return s;
    endfunction

endpackage

// File: design/utf8s_group.sv
module utf8s_group
    import utf8s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic [7:0]  i_byte,
    input  logic        i_end,
    output t_burst      o_burst
);

    t_grp_bytes        r_bytes, n_bytes;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic              cont;
    logic              close;
    logic [CNT_W-1:0]  cnt_a, cnt_b;
    t_grp_bytes        bytes_a;
    t_seq              s1, s2;
    logic [CNT_W-1:0]  ii, k;

    always_comb begin
        cont  = i_byte[7:6] == 2'b10;
        close = !cont && (r_cnt != '0);

        s1 = grp_emit(r_bytes, r_cnt);
        if (!close) begin
            s1.n = '0;
        end

        cnt_a = close ? '0 : r_cnt;
        for (int j = 0; j < MAX_SEQ_BYTES; j++) begin
            bytes_a[j] = (cnt_a == CNT_W'(j)) ? i_byte : r_bytes[j];
        end
        cnt_b = (cnt_a <= CNT_W'(MAX_SEQ_BYTES)) ? cnt_a + 3'd1 : cnt_a;

        s2 = grp_emit(bytes_a, cnt_b);
        if (!i_end) begin
            s2.n = '0;
        end

        for (int i = 0; i < MAX_RESULTS; i++) begin
            ii = CNT_W'(i);
            k  = ii - s1.n;
            if (ii < s1.n) begin
                o_burst.bytes[i] = s1.bytes[ii[1:0]];
            end else if (k < s2.n) begin
                o_burst.bytes[i] = s2.bytes[k[1:0]];
            end else begin
                o_burst.bytes[i] = 8'd0;
            end
        end
        o_burst.n        = s1.n + s2.n;
        o_burst.text_end = i_end;

        n_bytes = bytes_a;
        n_cnt   = i_end ? '0 : cnt_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_adv) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_bytes <= n_bytes;
        end
    end

    a_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_SEQ_BYTES + 1))
        else $error("group count beyond saturation");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_end |=> r_cnt == '0)
        else $error("group not cleared after end of text");

endmodule

// File: design/utf8s_out_buf.sv
module utf8s_out_buf
    import utf8s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_burst      i_burst,
    output logic        o_free,
    output logic        o_valid,
    input  logic        o_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_text_last
);

    logic [MAX_RESULTS-1:0][7:0] r_bytes;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_end;
    logic                        take;

    assign o_valid     = r_cnt != '0;
    assign take        = o_valid && o_ready;
    assign o_free      = (r_cnt == '0) || (r_cnt == 3'd1 && o_ready);
    assign o_out_byte  = r_bytes[0];
    assign o_run_last  = r_cnt == 3'd1;
    assign o_text_last = (r_cnt == 3'd1) && r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.n;
        end else if (take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
            r_end   <= i_burst.text_end;
        end else if (take) begin
            r_bytes <= r_bytes >> 8;
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("result count beyond seven");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> r_cnt == '0 || (r_cnt == 3'd1 && take))
        else $error("burst loaded over pending results");

endmodule

// File: design/utf8_lossy_sanitizer.sv
// UTF-8 lossy sanitizer. Bytes of a text come in one transaction at a time on
// the input channel, the last one flagged by i_end_of_text. Every byte that is
// not a continuation byte (10xxxxxx) opens a new group; a group closes on the
// next lead byte or at end of text and is then checked for well-formed UTF-8
// (no overlong forms, no surrogates, nothing above U+10FFFF). A good group
// comes out unchanged, a bad one (or one longer than four bytes) comes out as
// EF BF BD. o_run_last flags the last output byte caused by one input byte,
// o_text_last the final output byte of the text. Each input transaction passes
// through the input register and then the result buffer. One input byte is
// taken per cycle as long as each causes at most one output byte and o_ready
// stays high; a byte that causes more output bytes (up to seven) holds the
// input side while the single output port drains them one byte per handshake.
module utf8_lossy_sanitizer
    import utf8s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        i_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        o_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_text_last
);

    // input register
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_end;

    logic        buf_free;
    logic        adv;
    t_burst      burst;

    // the staged byte moves on once the result buffer is empty or its last byte is being taken
    assign adv     = r_in_vld && buf_free;
    assign i_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready && i_valid) begin
            r_in_byte <= i_in_byte;
            r_in_end  <= i_end_of_text;
        end
    end

    // group tracking and validity check, builds all output bytes for the item
    utf8s_group u_group (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_burst (burst)
    );

    // result buffer, drained one byte per output transaction
    utf8s_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (adv),
        .i_burst     (burst),
        .o_free      (buf_free),
        .o_valid     (o_valid),
        .o_ready     (o_ready),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_text_last (o_text_last)
    );

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv |=> r_in_vld && $stable(r_in_byte) && $stable(r_in_end))
        else $error("staged byte lost while stalled");

    a_text_last_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_text_last |-> o_run_last)
        else $error("text end without run end");

endmodule

// File: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8s_pkg::*;

    localparam int CYCLE_LIMIT    = 100000;
    localparam int DRAIN_CYCLES   = 16;   // plenty of margin for the block to drain
    localparam int HOLD_CYCLES    = 150;  // long receiver hold-off in the pressure phase
    localparam int ERR_PRINT_MAX  = 200;

    // one raw text byte waiting to be sent
    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } raw_byte_t;

    // one expected sanitized output byte
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       text_end;
    } sanitized_t;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [7:0] i_in_byte     = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       o_ready       = 1'b0;
    logic       i_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_text_last;

    utf8_lossy_sanitizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_ready       (i_ready),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .o_ready       (o_ready),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_text_last   (o_text_last)
    );

    always #10 i_clk = ~i_clk;

    // stimulus and expectation stores
    raw_byte_t  raw_text_q[$];     // bytes not yet accepted, front one is on the bus
    sanitized_t sanitized_q[$];    // predicted output bytes, oldest first
    sanitized_t burst_q[$];        // results of the transaction being predicted
    logic [7:0] text_buf[$];       // text under construction

    // predictor state: open group
    logic [7:0]       grp_buf [MAX_SEQ_BYTES];
    logic [CNT_W-1:0] grp_len = '0;

    // handshake bookkeeping
    int unsigned bytes_offered  = 0;
    int unsigned bytes_taken    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_ack       = 0;
    int          hold_left      = 0;
    int unsigned mismatch_cnt   = 0;
    int unsigned cycle_cnt      = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // well-formed check by lead byte ranges; bytes after the first must be
    // continuation bytes
    function automatic logic group_well_formed();
        logic [7:0] b0;
        logic [7:0] b1;
        logic       tail_ok;
        int         i;
        if (grp_len == 0 || grp_len > MAX_SEQ_BYTES)
            return 1'b0;
        b0      = grp_buf[0];
        b1      = grp_buf[1];
        tail_ok = 1'b1;
        for (i = 1; i < grp_len; i++)
            tail_ok = tail_ok && (grp_buf[i][7:6] == 2'b10);
        case (grp_len)
            3'd1: return b0 < 8'h80;
            3'd2: return tail_ok && b0 >= 8'hc2 && b0 <= 8'hdf;
            // no overlong three-byte form, no surrogate half
            3'd3: return tail_ok && b0[7:4] == 4'he
                         && !(b0 == 8'he0 && b1 < 8'ha0)
                         && !(b0 == 8'hed && b1 >= 8'ha0);
            // no overlong four-byte form, nothing above U+10FFFF
            default: return tail_ok && b0 >= 8'hf0 && b0 <= 8'hf4
                            && !(b0 == 8'hf0 && b1 < 8'h90)
                            && !(b0 == 8'hf4 && b1 > 8'h8f);
        endcase
    endfunction

    // emit the open group, unchanged or as the replacement character
    task automatic close_group();
        int i;
        if (group_well_formed()) begin
            for (i = 0; i < grp_len; i++)
                burst_q.push_back('{data: grp_buf[i], run_end: 1'b0, text_end: 1'b0});
        end else begin
            burst_q.push_back('{data: REPL_B0, run_end: 1'b0, text_end: 1'b0});
            burst_q.push_back('{data: REPL_B1, run_end: 1'b0, text_end: 1'b0});
            burst_q.push_back('{data: REPL_B2, run_end: 1'b0, text_end: 1'b0});
        end
        grp_len = '0;
    endtask

    // work out every output byte caused by one accepted input byte
    task automatic sanitize_byte(input logic [7:0] b, input logic eot);
        sanitized_t r;
        burst_q.delete();
        // a lead byte closes the open group
        if (b[7:6] != 2'b10 && grp_len != 0)
            close_group();
        // bytes past the fourth are dropped, count saturates at five
        if (grp_len < MAX_SEQ_BYTES)
            grp_buf[grp_len] = b;
        if (grp_len <= MAX_SEQ_BYTES)
            grp_len = grp_len + 1'b1;
        if (eot) begin
            close_group();
            r          = burst_q.pop_back();
            r.text_end = 1'b1;
            burst_q.push_back(r);
        end
        // a byte that only extends a group causes nothing
        if (burst_q.size() != 0) begin
            r         = burst_q.pop_back();
            r.run_end = 1'b1;
            burst_q.push_back(r);
        end
        while (burst_q.size() != 0)
            sanitized_q.push_back(burst_q.pop_front());
    endtask

    // ------------------------------------------------------------------
    // text generation
    // ------------------------------------------------------------------

    function automatic logic [7:0] cont_byte();
        return 8'h80 + 8'($urandom_range(63, 0));
    endfunction

    // well-formed character of one to four bytes with random content
    task automatic add_good_group();
        logic [7:0] lead;
        case ($urandom_range(3, 0))
            0: text_buf.push_back(8'($urandom_range(127, 0)));
            1: begin
                text_buf.push_back(8'($urandom_range(8'hdf, 8'hc2)));
                text_buf.push_back(cont_byte());
            end
            2: begin
                lead = 8'($urandom_range(8'hef, 8'he0));
                text_buf.push_back(lead);
                if (lead == 8'he0)
                    text_buf.push_back(8'($urandom_range(8'hbf, 8'ha0)));
                else if (lead == 8'hed)
                    text_buf.push_back(8'($urandom_range(8'h9f, 8'h80)));
                else
                    text_buf.push_back(cont_byte());
                text_buf.push_back(cont_byte());
            end
            default: begin
                lead = 8'($urandom_range(8'hf4, 8'hf0));
                text_buf.push_back(lead);
                if (lead == 8'hf0)
                    text_buf.push_back(8'($urandom_range(8'hbf, 8'h90)));
                else if (lead == 8'hf4)
                    text_buf.push_back(8'($urandom_range(8'h8f, 8'h80)));
                else
                    text_buf.push_back(cont_byte());
                text_buf.push_back(cont_byte());
                text_buf.push_back(cont_byte());
            end
        endcase
    endtask

    // broken or noisy group
    task automatic add_bad_group();
        case ($urandom_range(6, 0))
            0: text_buf.push_back(8'($urandom_range(255, 0)));
            // stray continuation bytes, a group of their own at text start
            1: repeat ($urandom_range(3, 1)) text_buf.push_back(cont_byte());
            // overlong forms
            2: begin
                case ($urandom_range(2, 0))
                    0: text_buf.push_back(8'($urandom_range(8'hc1, 8'hc0)));
                    1: begin
                        text_buf.push_back(8'he0);
                        text_buf.push_back(8'($urandom_range(8'h9f, 8'h80)));
                    end
                    default: begin
                        text_buf.push_back(8'hf0);
                        text_buf.push_back(8'($urandom_range(8'h8f, 8'h80)));
                        text_buf.push_back(cont_byte());
                    end
                endcase
                text_buf.push_back(cont_byte());
            end
            // surrogate halves
            3: begin
                text_buf.push_back(8'hed);
                text_buf.push_back(8'($urandom_range(8'hbf, 8'ha0)));
                text_buf.push_back(cont_byte());
            end
            // above U+10FFFF
            4: begin
                if ($urandom_range(1, 0) != 0) begin
                    text_buf.push_back(8'hf4);
                    text_buf.push_back(8'($urandom_range(8'hbf, 8'h90)));
                end else begin
                    text_buf.push_back(8'($urandom_range(8'hff, 8'hf5)));
                    text_buf.push_back(cont_byte());
                end
                text_buf.push_back(cont_byte());
                text_buf.push_back(cont_byte());
            end
            // truncated multi-byte sequence
            5: begin
                text_buf.push_back(8'($urandom_range(8'hf4, 8'he0)));
                text_buf.push_back(cont_byte());
            end
            // group longer than four bytes
            default: begin
                text_buf.push_back(8'($urandom_range(8'hf4, 8'hf0)));
                repeat ($urandom_range(6, 4)) text_buf.push_back(cont_byte());
            end
        endcase
    endtask

    // hand the built text to the driver, end of text on its last byte
    task automatic close_text();
        foreach (text_buf[i])
            raw_text_q.push_back('{data: text_buf[i], eot: (i == text_buf.size() - 1)});
        text_buf.delete();
    endtask

    // random texts of one to six groups until about n_bytes are queued
    task automatic queue_texts(input int n_bytes, input int bad_pct);
        int target;
        target = raw_text_q.size() + n_bytes;
        while (raw_text_q.size() < target) begin
            repeat ($urandom_range(6, 1)) begin
                if ($urandom_range(99, 0) < bad_pct)
                    add_bad_group();
                else
                    add_good_group();
            end
            close_text();
        end
    endtask

    // sender pause: nothing pending, every expected byte has come out
    task automatic wait_drained();
        do @(negedge i_clk);
        while (raw_text_q.size() != 0 || sanitized_q.size() != 0);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // driver: input side, changes on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (bytes_offered != bytes_taken) begin
            // transaction still on the bus, hold valid and payload
        end else if (raw_text_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            i_valid       <= 1'b1;
            i_in_byte     <= raw_text_q[0].data;
            i_end_of_text <= raw_text_q[0].eot;
            bytes_offered <= bytes_offered + 1;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver: random stalls, or a long counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            o_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            o_ready   <= 1'b0;
        end else begin
            o_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: both channels sampled on the rising edge
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= ERR_PRINT_MAX)
            $error("%s: expected %h, got %h", field, want, got);
    endtask

    always @(posedge i_clk) begin : sanitizer_watch
        sanitized_t want;
        if (i_rst_n) begin
            // output transaction against the oldest expectation
            if (o_valid && o_ready) begin
                if (sanitized_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= ERR_PRINT_MAX)
                        $error("unexpected output byte %h", o_out_byte);
                end else begin
                    want = sanitized_q.pop_front();
                    if (o_out_byte !== want.data)
                        report_mismatch("out_byte", want.data, o_out_byte);
                    if (o_run_last !== want.run_end)
                        report_mismatch("run_last", 8'(want.run_end), 8'(o_run_last));
                    if (o_text_last !== want.text_end)
                        report_mismatch("text_last", 8'(want.text_end), 8'(o_text_last));
                end
            end
            // input transaction feeds the predictor
            if (i_valid && i_ready) begin
                sanitize_byte(i_in_byte, i_end_of_text);
                void'(raw_text_q.pop_front());
                bytes_taken <= bytes_taken + 1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed texts, no idling
        // lone continuation at text start, min byte, min two-byte form with a
        // byte that causes nothing, min three-byte form, surrogate, max code
        // point, overlong group cut at five bytes that also ends the text
        text_buf = '{8'h80, 8'h00, 8'hc2, 8'h80, 8'he0, 8'ha0, 8'h80,
                     8'hed, 8'ha0, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf,
                     8'hf0, 8'h80, 8'h80, 8'h80, 8'h80};
        close_text();
        // new text after end: four-byte group closed by a lone lead at end,
        // the seven-result case
        text_buf = '{8'hf0, 8'h90, 8'h80, 8'h80, 8'hff};
        close_text();
        // overlong two-byte form
        text_buf = '{8'hc1, 8'hbf};
        close_text();
        // single ascii text
        text_buf = '{8'h7f};
        close_text();

        // random texts, no idling
        wait_drained();
        queue_texts(25, 30);

        // sender idle often
        wait_drained();
        send_idle_pct = 58;
        queue_texts(25, 30);

        // receiver stalls often
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 58;
        queue_texts(25, 30);

        // both sides idle now and then
        wait_drained();
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        queue_texts(25, 30);

        // long receiver hold-off while the sender keeps offering, so the
        // block backs up and drops i_ready
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = hold_req + 1;
        queue_texts(20, 10);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// File: filelist.f
design/utf8s_pkg.sv
design/utf8s_group.sv
design/utf8s_out_buf.sv
design/utf8_lossy_sanitizer.sv
bench/tb_top.sv
